FILE: rtl/pfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfm_pkg: shared types for the Pareto frontier merge block
// Request function codes, controller states and the command / status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfm_pkg;

  // Request function codes; code 3 is unused and ignored
  typedef enum logic [1:0] {
    FUNC_APPEND_A = 2'd0,
    FUNC_APPEND_B = 2'd1,
    FUNC_MERGE    = 2'd2
  } pfm_func_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_FETCH    = 3'd1,
    ST_STEP     = 3'd2,
    ST_EMIT_RD  = 3'd3,
    ST_EMIT_OUT = 3'd4
  } pfm_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic app_a;     // append pair to list A
    logic app_b;     // append pair to list B
    logic merge_ld;  // load walk pointers from the list counts
    logic rd_heads;  // read current tail entry of both lists
    logic step;      // choose one pair, keep it if y rises
    logic emit_ld;   // point emit address at the last kept pair
    logic emit_rd;   // read kept pair at emit address
    logic emit_out;  // move emit address down by one
    logic finish;    // clear both lists and the overflow flag
  } pfm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic lists_done;  // both walk pointers at zero
    logic none_kept;   // no pair kept during the walk
    logic emit_last;   // emit address at the first kept pair
  } pfm_sts_t;

endpackage

FILE: rtl/pfm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module pfm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage and registered read, no reset on payload
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pfm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfm_ctrl: controller for the Pareto frontier merge
// Takes requests, sequences the merge walk (fetch, then step) and the kept pair
// read-out, and drives the busy and result strobe outputs.
// ----------------------------------------------------------------------------
module pfm_ctrl
  import pfm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] func_i,
  input  pfm_sts_t   sts_i,
  output pfm_cmd_t   cmd_o,
  output logic       busy_o,
  output logic       strobe_o
);

  pfm_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (func_i)
            FUNC_APPEND_A: cmd_o.app_a = 1'b1;
            FUNC_APPEND_B: cmd_o.app_b = 1'b1;
            FUNC_MERGE: begin
              cmd_o.merge_ld = 1'b1;
              state_d        = ST_FETCH;
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        if (!sts_i.lists_done) begin
          cmd_o.rd_heads = 1'b1;
          state_d        = ST_STEP;
        end else if (sts_i.none_kept) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.emit_ld = 1'b1;
          state_d       = ST_EMIT_RD;
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_FETCH;
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (sts_i.emit_last) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.emit_out = 1'b1;
          state_d        = ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign strobe_o = (state_q == ST_EMIT_OUT);

endmodule

FILE: rtl/pfm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfm_dp: datapath for the Pareto frontier merge
// Holds both pair lists and the kept pairs in RAM, the list counts, the
// walk pointers, the running maximum of y and the read-out address.
// ----------------------------------------------------------------------------
module pfm_dp
  import pfm_pkg::*;
#(
  parameter int LIST_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pfm_cmd_t    cmd_i,
  input  logic [31:0] x_value_i,
  input  logic [31:0] y_value_i,
  output pfm_sts_t    sts_o,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic        last_pair_o,
  output logic        dropped_o
);

  localparam int AW     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int KD     = 2 * LIST_DEPTH;
  localparam int KAW    = $clog2(KD);
  localparam int KCW    = $clog2(KD + 1);

  logic [CNT_W-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CNT_W-1:0] ia_q, ia_d, ib_q, ib_d;
  logic [CNT_W-1:0] ia_dec, ib_dec;
  logic [KCW-1:0]   nk_q, nk_d, nk_dec;
  logic [KAW-1:0]   eaddr_q, eaddr_d;
  logic [31:0]      best_q, best_d;
  logic             ovf_q, ovf_d;

  logic        a_full, b_full;
  logic        wr_a, wr_b;
  logic [63:0] a_rd, b_rd, kept_rd, pick;
  logic        a_le_b, take_b, a_gt, b_gt, keep;

  // Append decode
  assign a_full = (cnt_a_q >= CNT_W'(LIST_DEPTH));
  assign b_full = (cnt_b_q >= CNT_W'(LIST_DEPTH));
  assign wr_a   = cmd_i.app_a && !a_full;
  assign wr_b   = cmd_i.app_b && !b_full;

  assign ia_dec = ia_q - CNT_W'(1);
  assign ib_dec = ib_q - CNT_W'(1);
  assign nk_dec = nk_q - KCW'(1);

  // Pair lists, x in the upper half, y in the lower
  pfm_ram #(.WIDTH(64), .DEPTH(LIST_DEPTH)) u_list_a (
    .clk_i   (clk_i),
    .we_i    (wr_a),
    .waddr_i (cnt_a_q[AW-1:0]),
    .wdata_i ({x_value_i, y_value_i}),
    .re_i    (cmd_i.rd_heads),
    .raddr_i (ia_dec[AW-1:0]),
    .rdata_o (a_rd)
  );

  pfm_ram #(.WIDTH(64), .DEPTH(LIST_DEPTH)) u_list_b (
    .clk_i   (clk_i),
    .we_i    (wr_b),
    .waddr_i (cnt_b_q[AW-1:0]),
    .wdata_i ({x_value_i, y_value_i}),
    .re_i    (cmd_i.rd_heads),
    .raddr_i (ib_dec[AW-1:0]),
    .rdata_o (b_rd)
  );

  // Choice between list tails: lexicographic compare, B wins a tie
  assign a_le_b = (a_rd <= b_rd);
  assign take_b = (ia_q == '0) || ((ib_q != '0) && a_le_b);
  assign a_gt   = (a_rd[31:0] > best_q);
  assign b_gt   = (b_rd[31:0] > best_q);
  assign pick   = take_b ? b_rd : a_rd;
  assign keep   = take_b ? b_gt : a_gt;

  // Kept pairs, written in order of choice, read back in reverse
  pfm_ram #(.WIDTH(64), .DEPTH(KD)) u_kept (
    .clk_i   (clk_i),
    .we_i    (cmd_i.step && keep),
    .waddr_i (nk_q[KAW-1:0]),
    .wdata_i (pick),
    .re_i    (cmd_i.emit_rd),
    .raddr_i (eaddr_q),
    .rdata_o (kept_rd)
  );

  // Next-state logic for counters and walk registers
  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    ovf_d   = ovf_q;
    ia_d    = ia_q;
    ib_d    = ib_q;
    nk_d    = nk_q;
    best_d  = best_q;
    eaddr_d = eaddr_q;

    if (cmd_i.app_a) begin
      if (a_full) ovf_d = 1'b1;
      else        cnt_a_d = cnt_a_q + CNT_W'(1);
    end
    if (cmd_i.app_b) begin
      if (b_full) ovf_d = 1'b1;
      else        cnt_b_d = cnt_b_q + CNT_W'(1);
    end
    if (cmd_i.merge_ld) begin
      ia_d   = cnt_a_q;
      ib_d   = cnt_b_q;
      nk_d   = '0;
      best_d = '0;
    end
    if (cmd_i.step) begin
      if (take_b) ib_d = ib_dec;
      else        ia_d = ia_dec;
      if (keep) begin
        nk_d   = nk_q + KCW'(1);
        best_d = pick[31:0];
      end
    end
    if (cmd_i.emit_ld) begin
      eaddr_d = nk_dec[KAW-1:0];
    end
    if (cmd_i.emit_out) begin
      eaddr_d = eaddr_q - KAW'(1);
    end
    if (cmd_i.finish) begin
      cnt_a_d = '0;
      cnt_b_d = '0;
      ovf_d   = 1'b0;
    end
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ovf_q   <= 1'b0;
      ia_q    <= '0;
      ib_q    <= '0;
      nk_q    <= '0;
      best_q  <= '0;
      eaddr_q <= '0;
    end else begin
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      ovf_q   <= ovf_d;
      ia_q    <= ia_d;
      ib_q    <= ib_d;
      nk_q    <= nk_d;
      best_q  <= best_d;
      eaddr_q <= eaddr_d;
    end
  end

  // Status and result fields
  assign sts_o.lists_done = (ia_q == '0) && (ib_q == '0);
  assign sts_o.none_kept  = (nk_q == '0);
  assign sts_o.emit_last  = (eaddr_q == '0);

  assign out_x_o     = kept_rd[63:32];
  assign out_y_o     = kept_rd[31:0];
  assign last_pair_o = (eaddr_q == '0);
  assign dropped_o   = ovf_q;

endmodule

FILE: rtl/pareto_frontier_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pareto_frontier_merge: two-list Pareto frontier merge
// Loads two sorted lists of (x,y) pairs and merges them into a frontier.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start_i is high and busy_o is low. func_i selects
//   append to list A, append to list B, or merge. Appends finish in the
//   cycle they are taken and busy_o stays low, so one append per cycle.
//   A full list drops the pair and sets the dropped flag until the next merge.
//   A merge walks both lists from their tails: for each loaded pair, a list
//   RAM read, then a compare and keep; then it sets up the read-out and, for
//   each kept pair, does a kept RAM read, then presents the result.
//   Results appear on out_x_o/out_y_o/last_pair_o/dropped_o for one cycle
//   each with strobe_o high, x ascending, last_pair_o on the final one.
//   The receiver cannot stall; every strobed result is taken.
//   A merge clears both lists and the dropped flag at its end; with
//   nothing kept, no result is produced. Reset empties both lists and
//   clears the flag.
// ----------------------------------------------------------------------------
module pareto_frontier_merge
  import pfm_pkg::*;
#(
  parameter int LIST_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] x_value_i,
  input  logic [31:0] y_value_i,
  output logic        strobe_o,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic        last_pair_o,
  output logic        dropped_o
);

  pfm_cmd_t cmd;
  pfm_sts_t sts;

  // Controller
  pfm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .func_i   (func_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .strobe_o (strobe_o)
  );

  // Datapath
  pfm_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .x_value_i   (x_value_i),
    .y_value_i   (y_value_i),
    .sts_o       (sts),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .last_pair_o (last_pair_o),
    .dropped_o   (dropped_o)
  );

  // Merge request always occupies the block in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (func_i == FUNC_MERGE) |=> busy_o)
    else $error("merge request did not raise busy");

  // A result that is not the last is followed by more work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_pair_o |=> busy_o && !strobe_o)
    else $error("merge ended before the last pair");

  // The last result ends the merge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_pair_o |=> !busy_o)
    else $error("block still busy after the last pair");

  // The walk never steps once both lists are exhausted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !sts.lists_done)
    else $error("walk step with both lists empty");

endmodule

FILE: bench/pfm_frontier_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfm_frontier_checker: request monitor and frontier predictor
// Watches accepted requests, keeps its own copy of both pair lists and the
// overflow flag, works out the frontier that each merge must produce and
// compares every strobed result against the oldest pending frontier pair.
// ----------------------------------------------------------------------------
module pfm_frontier_checker
  import pfm_pkg::*;
#(
  parameter int LIST_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] x_value_i,
  input  logic [31:0] y_value_i,
  input  logic        strobe_o,
  input  logic [31:0] out_x_o,
  input  logic [31:0] out_y_o,
  input  logic        last_pair_o,
  input  logic        dropped_o,
  output int          error_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          overflow_count_o
);

  localparam int KEPT_DEPTH = 64;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
  } pair_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
    logic        drop;
  } frontier_pair_t;

  // Shadow copy of the block state
  pair_t          list_a [LIST_DEPTH];
  pair_t          list_b [LIST_DEPTH];
  int             fill_a;
  int             fill_b;
  logic           overflow_flag;
  frontier_pair_t frontier_q [$];

  // Walk both lists from their tails and queue the kept pairs, x ascending
  task automatic predict_frontier();
    int             ia;
    int             ib;
    logic [31:0]    best_y;
    pair_t          kept [$];
    pair_t          pick;
    logic           take_b;
    frontier_pair_t res;
    ia     = fill_a;
    ib     = fill_b;
    best_y = '0;
    while (ia > 0 || ib > 0) begin
      if (ia == 0) begin
        take_b = 1'b1;
      end else if (ib == 0) begin
        take_b = 1'b0;
      end else if (list_a[ia-1].x != list_b[ib-1].x) begin
        take_b = list_a[ia-1].x < list_b[ib-1].x;
      end else begin
        take_b = list_a[ia-1].y <= list_b[ib-1].y;  // tie goes to B
      end
      if (take_b) begin
        ib--;
        pick = list_b[ib];
      end else begin
        ia--;
        pick = list_a[ia];
      end
      if (pick.y > best_y && kept.size() < KEPT_DEPTH) begin
        kept   = {kept, pick};
        best_y = pick.y;
      end
    end
    for (int k = kept.size() - 1; k >= 0; k--) begin
      res.x      = kept[k].x;
      res.y      = kept[k].y;
      res.last   = (k == 0);
      res.drop   = overflow_flag;
      frontier_q = {frontier_q, res};
    end
    fill_a        = 0;
    fill_b        = 0;
    overflow_flag = 1'b0;
  endtask

  // Results first, then the request taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    frontier_pair_t exp_r;
    if (!rst_ni) begin
      fill_a           = 0;
      fill_b           = 0;
      overflow_flag    = 1'b0;
      frontier_q.delete();
      error_count_o    = 0;
      pending_o        = 0;
      checked_o        = 0;
      overflow_count_o = 0;
    end else begin
      if (strobe_o) begin
        if (frontier_q.size() == 0) begin
          error_count_o++;
          if (error_count_o <= REPORT_MAX)
            $display("checker: unexpected result x=%h y=%h last=%b dropped=%b",
                     out_x_o, out_y_o, last_pair_o, dropped_o);
        end else begin
          exp_r = frontier_q.pop_front();
          checked_o++;
          if (out_x_o !== exp_r.x || out_y_o !== exp_r.y ||
              last_pair_o !== exp_r.last || dropped_o !== exp_r.drop) begin
            error_count_o++;
            if (error_count_o <= REPORT_MAX)
              $display(
                "checker: mismatch exp x=%h y=%h last=%b drop=%b, got x=%h y=%h last=%b drop=%b",
                exp_r.x, exp_r.y, exp_r.last, exp_r.drop,
                out_x_o, out_y_o, last_pair_o, dropped_o);
          end
        end
      end
      if (start_i && !busy_o) begin
        if (func_i == FUNC_APPEND_A) begin
          if (fill_a < LIST_DEPTH) begin
            list_a[fill_a] = '{x: x_value_i, y: y_value_i};
            fill_a++;
          end else begin
            overflow_flag = 1'b1;
            overflow_count_o++;
          end
        end else if (func_i == FUNC_APPEND_B) begin
          if (fill_b < LIST_DEPTH) begin
            list_b[fill_b] = '{x: x_value_i, y: y_value_i};
            fill_b++;
          end else begin
            overflow_flag = 1'b1;
            overflow_count_o++;
          end
        end else if (func_i == FUNC_MERGE) begin
          predict_frontier();
        end
      end
      pending_o = frontier_q.size();
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the Pareto frontier merge block
// Loads pair lists into A and B and merges them: a few hand-picked cases,
// then random sorted, unsorted and overflowing loads with sender gaps.
// The checker beside the block predicts and compares every frontier pair.
// ----------------------------------------------------------------------------
module tb;
  import pfm_pkg::*;

  localparam int         LIST_DEPTH   = 32;
  localparam int         ITEMS        = 230;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         DRAIN_CYCLES = 300;
  localparam int         MAX_LOAD     = 48;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  func_i;
  logic [31:0] x_value_i;
  logic [31:0] y_value_i;
  logic        strobe_o;
  logic [31:0] out_x_o;
  logic [31:0] out_y_o;
  logic        last_pair_o;
  logic        dropped_o;

  int error_count;
  int pending;
  int checked;
  int overflow_count;

  int idle_pct;
  int req_count;
  int merge_count;

  logic [63:0] load_a [MAX_LOAD];
  logic [63:0] load_b [MAX_LOAD];

  pareto_frontier_merge #(
    .LIST_DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .func_i     (func_i),
    .x_value_i  (x_value_i),
    .y_value_i  (y_value_i),
    .strobe_o   (strobe_o),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .last_pair_o(last_pair_o),
    .dropped_o  (dropped_o)
  );

  pfm_frontier_checker #(
    .LIST_DEPTH(LIST_DEPTH)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .x_value_i       (x_value_i),
    .y_value_i       (y_value_i),
    .strobe_o        (strobe_o),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .last_pair_o     (last_pair_o),
    .dropped_o       (dropped_o),
    .error_count_o   (error_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .overflow_count_o(overflow_count)
  );

  // Clock, 4 ns period
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("tb: errors");
    $finish;
  end

  // Idle share follows the position in the run: none, heavy, none, light
  function automatic int phase_idle(int n);
    case ((n * 4 / ITEMS) % 4)
      1:       return 78;
      3:       return 16;
      default: return 0;
    endcase
  endfunction

  // Drive one request at the falling edge and hold it until taken
  task automatic send_request(input logic [1:0] f, input logic [31:0] x,
                              input logic [31:0] y);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i   <= 1'b1;
    func_i    <= f;
    x_value_i <= x;
    y_value_i <= y;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    if (f != FUNC_UNUSED) req_count++;
    if (f == FUNC_MERGE) merge_count++;
    idle_pct = phase_idle(req_count);
  endtask

  function automatic logic [31:0] pick_value(int mode);
    case (mode)
      1:       return 32'($urandom_range(0, 7));
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0;
          1:       return 32'h1;
          2:       return 32'hFFFF_FFFE;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Fill a load buffer with n pairs, sorted ascending unless asked otherwise
  task automatic build_list(input int n, input bit sorted, output logic [63:0] lst [MAX_LOAD]);
    int          xmode;
    int          ymode;
    logic [63:0] tmp;
    xmode = $urandom_range(0, 2);
    ymode = $urandom_range(0, 2);
    for (int i = 0; i < MAX_LOAD; i++) lst[i] = '0;
    for (int i = 0; i < n; i++) lst[i] = {pick_value(xmode), pick_value(ymode)};
    if (sorted) begin
      for (int i = 1; i < n; i++) begin
        for (int j = i; j > 0 && lst[j-1] > lst[j]; j--) begin
          tmp      = lst[j];
          lst[j]   = lst[j-1];
          lst[j-1] = tmp;
        end
      end
    end
  endtask

  // Interleave the appends of both lists, then merge
  task automatic load_and_merge(input int na, input int nb, input bit sorted);
    int ia;
    int ib;
    build_list(na, sorted, load_a);
    build_list(nb, sorted, load_b);
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
        send_request(FUNC_APPEND_A, load_a[ia][63:32], load_a[ia][31:0]);
        ia++;
      end else begin
        send_request(FUNC_APPEND_B, load_b[ib][63:32], load_b[ib][31:0]);
        ib++;
      end
      if ($urandom_range(0, 19) == 0) send_request(FUNC_UNUSED, $urandom, $urandom);
    end
    send_request(FUNC_MERGE, $urandom, $urandom);
  endtask

  function automatic int small_size();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, LIST_DEPTH);
    return $urandom_range(0, 6);
  endfunction

  initial begin
    int  kind;
    bit  first_rand;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    func_i      = FUNC_APPEND_A;
    x_value_i   = '0;
    y_value_i   = '0;
    idle_pct    = 0;
    req_count   = 0;
    merge_count = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: merge of empty lists, unused code, nothing kept
    send_request(FUNC_MERGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(FUNC_APPEND_A, 32'h0, 32'h0);
    send_request(FUNC_APPEND_B, 32'h5, 32'h0);
    send_request(FUNC_MERGE, 32'h0, 32'h0);
    // Tie between the tails of A and B, extreme coordinates
    send_request(FUNC_APPEND_A, 32'h0, 32'h5);
    send_request(FUNC_APPEND_B, 32'h3, 32'h9);
    send_request(FUNC_APPEND_A, 32'h7, 32'hFFFF_FFFF);
    send_request(FUNC_APPEND_B, 32'h7, 32'hFFFF_FFFF);
    send_request(FUNC_UNUSED, 32'h0, 32'h0);
    send_request(FUNC_APPEND_B, 32'hFFFF_FFFF, 32'h1);
    send_request(FUNC_MERGE, 32'h0, 32'h0);
    // Only list A, every pair on the frontier
    send_request(FUNC_APPEND_A, 32'h0, 32'hFFFF_FFFF);
    send_request(FUNC_APPEND_A, 32'h1, 32'h2);
    send_request(FUNC_APPEND_A, 32'hFFFF_FFFF, 32'h1);
    send_request(FUNC_MERGE, 32'h0, 32'h0);
    // Only list B, unsorted order
    send_request(FUNC_APPEND_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(FUNC_APPEND_B, 32'h0, 32'h1);
    send_request(FUNC_APPEND_B, 32'h8000_0000, 32'h8000_0000);
    send_request(FUNC_MERGE, 32'h0, 32'h0);

    // Random loads: mostly sorted, some unsorted, overflowing or noise
    first_rand = 1'b1;
    while (req_count < ITEMS) begin
      kind = first_rand ? 85 : $urandom_range(0, 99);
      first_rand = 1'b0;
      if (kind < 70) begin
        load_and_merge(small_size(), small_size(), 1'b1);
      end else if (kind < 80) begin
        load_and_merge(small_size(), small_size(), 1'b0);
      end else if (kind < 90) begin
        if ($urandom_range(0, 1) == 1)
          load_and_merge($urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 3), small_size(), 1'b1);
        else
          load_and_merge(small_size(), $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 3), 1'b1);
      end else begin
        send_request(FUNC_UNUSED, $urandom, $urandom);
        send_request(FUNC_MERGE, $urandom, $urandom);
      end
    end
    start_i <= 1'b0;

    // Drain: wait for the last frontier, then a margin for strays
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d requests, %0d merges, %0d frontier pairs checked",
             req_count, merge_count, checked);
    $display("summary: %0d appends dropped on full lists, %0d failures",
             overflow_count, error_count);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pfm_pkg.sv
rtl/pfm_ram.sv
rtl/pfm_ctrl.sv
rtl/pfm_dp.sv
rtl/pareto_frontier_merge.sv
bench/pfm_frontier_checker.sv
bench/tb.sv
